// ----- design/mpsr_pkg.sv -----
// Shared types, constants and the stream id lookup for the media packet stream router.
// Depends on nothing; the top level refers to it by scoped names.
package mpsr_pkg;

    localparam int unsigned MAX_IDS      = 8;
    localparam int unsigned HEADER_BYTES = 12;
    localparam int unsigned ID_WIDTH     = 16;
    localparam int unsigned CFG_WIDTH    = 64;

    // Byte positions inside the 12-byte packet header.
    localparam logic [3:0] HDR_LEN_HI  = 4'd2;
    localparam logic [3:0] HDR_LEN_LO  = 4'd3;
    localparam logic [3:0] HDR_ID_HI   = 4'd4;
    localparam logic [3:0] HDR_ID_LO   = 4'd5;
    localparam logic [3:0] HDR_TIME_0  = 4'd6;
    localparam logic [3:0] HDR_TIME_1  = 4'd7;
    localparam logic [3:0] HDR_TIME_2  = 4'd8;
    localparam logic [3:0] HDR_TIME_3  = 4'd9;
    localparam logic [3:0] HDR_FLAGS   = 4'd11;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PACKET_COUNT   = 3'd0;
    localparam logic [2:0] CFG_AUDIO_COUNT    = 3'd1;
    localparam logic [2:0] CFG_AUDIO_IDS_LOW  = 3'd2;
    localparam logic [2:0] CFG_AUDIO_IDS_HIGH = 3'd3;
    localparam logic [2:0] CFG_VIDEO_COUNT    = 3'd4;
    localparam logic [2:0] CFG_VIDEO_IDS_LOW  = 3'd5;
    localparam logic [2:0] CFG_VIDEO_IDS_HIGH = 3'd6;

    // Result event codes.
    localparam logic [2:0] EV_PAYLOAD    = 3'd0;
    localparam logic [2:0] EV_EMPTY      = 3'd1;
    localparam logic [2:0] EV_BAD_LENGTH = 3'd2;
    localparam logic [2:0] EV_UNKNOWN    = 3'd3;
    localparam logic [2:0] EV_END        = 3'd4;

    localparam logic CLASS_AUDIO = 1'b0;
    localparam logic CLASS_VIDEO = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'b01,
        PH_BODY   = 2'b10
    } phase_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic        stream_class;
        logic [7:0]  payload_byte;
        logic [15:0] packet_stream_id;
        logic [31:0] packet_time;
        logic        last_of_packet;
    } result_t;

    // Compares the id against all listed entries at once; entries at or above
    // the count are ignored, so counts above the list size act as a full list.
    function automatic logic id_match(
        input logic [ID_WIDTH-1:0]  id,
        input logic [3:0]           count,
        input logic [CFG_WIDTH-1:0] ids_low,
        input logic [CFG_WIDTH-1:0] ids_high
    );
        logic [2*CFG_WIDTH-1:0] ids;
        logic                   hit;
        ids = {ids_high, ids_low};
        hit = 1'b0;
        for (int i = 0; i < int'(MAX_IDS); i++) begin
            if ((5'(i) < {1'b0, count}) && (ids[i*ID_WIDTH +: ID_WIDTH] == id)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// ----- design/media_packet_stream_router.sv -----
// Media packet stream router: one header byte or payload byte per clock while s_ready is high.
// A result is registered into the m_ channel output register, or into the skid register
// when the output is stalled. The header parse and the parallel id compares sit
// between the state registers and the result register, and a skid register keeps
// s_ready registered. Reset clears all parse state, the result and skid valid flags,
// and every configuration register to zero.
module media_packet_stream_router (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic        m_stream_class,
    output logic [7:0]  m_payload_byte,
    output logic [15:0] m_packet_stream_id,
    output logic [31:0] m_packet_time,
    output logic        m_last_of_packet
);

    // Configuration registers.
    logic [31:0] packet_count_reg;
    logic [3:0]  audio_count_reg;
    logic [63:0] audio_ids_low_reg;
    logic [63:0] audio_ids_high_reg;
    logic [3:0]  video_count_reg;
    logic [63:0] video_ids_low_reg;
    logic [63:0] video_ids_high_reg;

    // Parse state.
    mpsr_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  hdr_idx_reg, hdr_idx_next, hdr_idx_cur;
    logic [15:0] packet_length_reg, packet_length_next, length_lo;
    logic [15:0] current_id_reg, current_id_next;
    logic [31:0] current_time_reg, current_time_next;
    logic [15:0] bytes_left_reg, bytes_left_next, payload_left;
    logic [31:0] packets_taken_reg, packets_taken_next;
    logic        route_class_reg, route_class_next;
    logic        forwarding_reg, forwarding_next;

    logic        is_audio, is_video;
    logic        res_valid;
    mpsr_pkg::result_t res;

    // Output and skid registers.
    mpsr_pkg::result_t out_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;
    logic        in_take;

    assign s_ready = ~skid_valid_reg;
    assign in_take = s_valid & s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            packet_count_reg   <= '0;
            audio_count_reg    <= '0;
            audio_ids_low_reg  <= '0;
            audio_ids_high_reg <= '0;
            video_count_reg    <= '0;
            video_ids_low_reg  <= '0;
            video_ids_high_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mpsr_pkg::CFG_PACKET_COUNT:   packet_count_reg   <= cfg_wdata[31:0];
                mpsr_pkg::CFG_AUDIO_COUNT:    audio_count_reg    <= cfg_wdata[3:0];
                mpsr_pkg::CFG_AUDIO_IDS_LOW:  audio_ids_low_reg  <= cfg_wdata;
                mpsr_pkg::CFG_AUDIO_IDS_HIGH: audio_ids_high_reg <= cfg_wdata;
                mpsr_pkg::CFG_VIDEO_COUNT:    video_count_reg    <= cfg_wdata[3:0];
                mpsr_pkg::CFG_VIDEO_IDS_LOW:  video_ids_low_reg  <= cfg_wdata;
                mpsr_pkg::CFG_VIDEO_IDS_HIGH: video_ids_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign is_audio = mpsr_pkg::id_match(current_id_reg, audio_count_reg,
                                         audio_ids_low_reg, audio_ids_high_reg);
    assign is_video = mpsr_pkg::id_match(current_id_reg, video_count_reg,
                                         video_ids_low_reg, video_ids_high_reg);

    assign hdr_idx_cur  = (hdr_idx_reg >= 4'(mpsr_pkg::HEADER_BYTES)) ? '0 : hdr_idx_reg;
    assign length_lo    = {packet_length_reg[15:8], s_data_byte};
    assign payload_left = packet_length_reg - 16'(mpsr_pkg::HEADER_BYTES);

    always_comb begin
        phase_next         = phase_reg;
        hdr_idx_next       = hdr_idx_reg;
        packet_length_next = packet_length_reg;
        current_id_next    = current_id_reg;
        current_time_next  = current_time_reg;
        bytes_left_next    = bytes_left_reg;
        packets_taken_next = packets_taken_reg;
        route_class_next   = route_class_reg;
        forwarding_next    = forwarding_reg;
        res_valid          = 1'b0;
        res                = '0;

        if (phase_reg == mpsr_pkg::PH_BODY && bytes_left_reg != '0) begin
            bytes_left_next = bytes_left_reg - 16'd1;
            if (bytes_left_next == '0) begin
                phase_next   = mpsr_pkg::PH_HEADER;
                hdr_idx_next = '0;
            end
            if (forwarding_reg) begin
                res_valid            = 1'b1;
                res.event_res        = mpsr_pkg::EV_PAYLOAD;
                res.stream_class     = route_class_reg;
                res.payload_byte     = s_data_byte;
                res.packet_stream_id = current_id_reg;
                res.packet_time      = current_time_reg;
                res.last_of_packet   = (bytes_left_next == '0);
            end
        end else begin
            phase_next   = mpsr_pkg::PH_HEADER;
            hdr_idx_next = hdr_idx_cur;
            if (hdr_idx_cur == '0 && packets_taken_reg >= packet_count_reg) begin
                // End reached: the byte is swallowed and the parse stays put.
                res_valid     = 1'b1;
                res.event_res = mpsr_pkg::EV_END;
            end else begin
                hdr_idx_next = hdr_idx_cur + 4'd1;
                unique case (hdr_idx_cur)
                    mpsr_pkg::HDR_LEN_HI: begin
                        packet_length_next = {s_data_byte, 8'h00};
                    end
                    mpsr_pkg::HDR_LEN_LO: begin
                        packet_length_next = length_lo;
                        if (length_lo < 16'(mpsr_pkg::HEADER_BYTES)) begin
                            // Short length: drop that many bytes, packet not counted.
                            bytes_left_next = length_lo;
                            forwarding_next = 1'b0;
                            hdr_idx_next    = '0;
                            if (length_lo != '0) begin
                                phase_next = mpsr_pkg::PH_BODY;
                            end
                            res_valid     = 1'b1;
                            res.event_res = mpsr_pkg::EV_BAD_LENGTH;
                        end
                    end
                    mpsr_pkg::HDR_ID_HI, mpsr_pkg::HDR_ID_LO: begin
                        current_id_next = {current_id_reg[7:0], s_data_byte};
                    end
                    mpsr_pkg::HDR_TIME_0, mpsr_pkg::HDR_TIME_1,
                    mpsr_pkg::HDR_TIME_2, mpsr_pkg::HDR_TIME_3: begin
                        current_time_next = {current_time_reg[23:0], s_data_byte};
                    end
                    mpsr_pkg::HDR_FLAGS: begin
                        packets_taken_next   = packets_taken_reg + 32'd1;
                        bytes_left_next      = payload_left;
                        hdr_idx_next         = '0;
                        res.packet_stream_id = current_id_reg;
                        res.packet_time      = current_time_reg;
                        if (!is_audio && !is_video) begin
                            route_class_next = mpsr_pkg::CLASS_AUDIO;
                            forwarding_next  = 1'b0;
                            if (payload_left != '0) begin
                                phase_next = mpsr_pkg::PH_BODY;
                            end
                            res_valid     = 1'b1;
                            res.event_res = mpsr_pkg::EV_UNKNOWN;
                        end else begin
                            // Video wins when the id is in both lists.
                            route_class_next = is_video ? mpsr_pkg::CLASS_VIDEO
                                                        : mpsr_pkg::CLASS_AUDIO;
                            forwarding_next  = 1'b1;
                            if (payload_left == '0) begin
                                res_valid        = 1'b1;
                                res.event_res    = mpsr_pkg::EV_EMPTY;
                                res.stream_class = route_class_next;
                            end else begin
                                phase_next = mpsr_pkg::PH_BODY;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= mpsr_pkg::PH_HEADER;
            hdr_idx_reg       <= '0;
            packet_length_reg <= '0;
            current_id_reg    <= '0;
            current_time_reg  <= '0;
            bytes_left_reg    <= '0;
            packets_taken_reg <= '0;
            route_class_reg   <= 1'b0;
            forwarding_reg    <= 1'b0;
        end else if (in_take) begin
            phase_reg         <= phase_next;
            hdr_idx_reg       <= hdr_idx_next;
            packet_length_reg <= packet_length_next;
            current_id_reg    <= current_id_next;
            current_time_reg  <= current_time_next;
            bytes_left_reg    <= bytes_left_next;
            packets_taken_reg <= packets_taken_next;
            route_class_reg   <= route_class_next;
            forwarding_reg    <= forwarding_next;
        end
    end

    // The skid register catches a result when the output register is stalled,
    // so s_ready depends only on a flop.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_take && res_valid;
        end else if (in_take && res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_reg <= skid_reg;
            end
        end else if (!out_valid_reg || m_ready) begin
            out_reg <= res;
        end else if (in_take && res_valid) begin
            skid_reg <= res;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_event_res        = out_reg.event_res;
    assign m_stream_class     = out_reg.stream_class;
    assign m_payload_byte     = out_reg.payload_byte;
    assign m_packet_stream_id = out_reg.packet_stream_id;
    assign m_packet_time      = out_reg.packet_time;
    assign m_last_of_packet   = out_reg.last_of_packet;

    // A held result in the skid register always has one ahead of it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a transaction while the output is empty");

    // The body phase always has bytes left to consume.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == mpsr_pkg::PH_BODY) |-> (bytes_left_reg != '0))
        else $error("body phase with no bytes left");

    // The header index never runs past the header.
    assert property (@(posedge aclk) disable iff (!aresetn)
        hdr_idx_reg < 4'(mpsr_pkg::HEADER_BYTES))
        else $error("header index out of range");

    // Packet end is flagged only on forwarded payload bytes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.last_of_packet) |->
            (out_reg.event_res == mpsr_pkg::EV_PAYLOAD))
        else $error("last_of_packet on a non-payload transaction");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for media_packet_stream_router: byte stream in, routed events out.
// Depends on mpsr_pkg and the router RTL; a built-in router model predicts events not given by directed rows.
module tb_top;

    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASES         = 7;
    localparam int DIRECTED_COUNT = 31;
    localparam int CONFIG_ROW     = 1;
    localparam int PHASE_TARGET   = 85;

    typedef struct packed {
        logic [7:0]        data;
        logic              given;
        logic              has_event;
        mpsr_pkg::result_t want;
    } byte_row_t;

    localparam mpsr_pkg::result_t NO_EVENT  = '0;
    localparam mpsr_pkg::result_t END_EVENT = '{mpsr_pkg::EV_END, mpsr_pkg::CLASS_AUDIO,
                                                8'h00, 16'h0000, 32'h0, 1'b0};
    localparam mpsr_pkg::result_t BAD_EVENT = '{mpsr_pkg::EV_BAD_LENGTH, mpsr_pkg::CLASS_AUDIO,
                                                8'h00, 16'h0000, 32'h0, 1'b0};

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_event_res;
    logic        m_stream_class;
    logic [7:0]  m_payload_byte;
    logic [15:0] m_packet_stream_id;
    logic [31:0] m_packet_time;
    logic        m_last_of_packet;

    media_packet_stream_router dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_res        (m_event_res),
        .m_stream_class     (m_stream_class),
        .m_payload_byte     (m_payload_byte),
        .m_packet_stream_id (m_packet_stream_id),
        .m_packet_time      (m_packet_time),
        .m_last_of_packet   (m_last_of_packet)
    );

    always #6 aclk = ~aclk;

    // Router model: configuration copy and parse state.
    logic [31:0] lim_packets = '0;
    logic [3:0]  audio_n     = '0;
    logic [63:0] audio_lo    = '0;
    logic [63:0] audio_hi    = '0;
    logic [3:0]  video_n     = '0;
    logic [63:0] video_lo    = '0;
    logic [63:0] video_hi    = '0;

    mpsr_pkg::phase_t rt_phase = mpsr_pkg::PH_HEADER;
    logic [3:0]  hdr_pos     = '0;
    logic [15:0] pkt_len     = '0;
    logic [15:0] pkt_id      = '0;
    logic [31:0] pkt_time    = '0;
    logic [15:0] body_left   = '0;
    logic [31:0] pkts_taken  = '0;
    logic        pkt_class   = mpsr_pkg::CLASS_AUDIO;
    logic        pkt_forward = 1'b0;

    mpsr_pkg::result_t routed_events[$];
    byte_row_t   offered_bytes[$];
    logic [7:0]  phase_bytes[$];
    logic [7:0]  carry_bytes[$];

    int error_count    = 0;
    int bytes_taken    = 0;
    int settings_used  = 0;
    int event_counts[5] = '{default: 0};
    int stall_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int send_burst     = 0;
    int recv_burst     = 0;
    int hold_requests  = 0;

    byte_row_t directed_rows [DIRECTED_COUNT] = '{
        '{8'hA5, 1'b1, 1'b1, END_EVENT},
        // Length of zero: reported on the second length byte, nothing dropped.
        '{8'hFF, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b1, 1'b1, BAD_EVENT},
        // Id 0x1234 sits in both lists, so its one payload byte goes out as video.
        '{8'h00, 1'b0, 1'b0, NO_EVENT},
        '{8'hFF, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, NO_EVENT},
        '{8'h0D, 1'b0, 1'b0, NO_EVENT},
        '{8'h12, 1'b0, 1'b0, NO_EVENT},
        '{8'h34, 1'b0, 1'b0, NO_EVENT},
        '{8'hDE, 1'b0, 1'b0, NO_EVENT},
        '{8'hAD, 1'b0, 1'b0, NO_EVENT},
        '{8'hBE, 1'b0, 1'b0, NO_EVENT},
        '{8'hEF, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, NO_EVENT},
        '{8'hFF, 1'b0, 1'b0, NO_EVENT},
        '{8'hFF, 1'b1, 1'b1, '{mpsr_pkg::EV_PAYLOAD, mpsr_pkg::CLASS_VIDEO, 8'hFF,
                               16'h1234, 32'hDEADBEEF, 1'b1}},
        // Header-only packet with an id in neither list.
        '{8'h00, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, NO_EVENT},
        '{8'h0C, 1'b0, 1'b0, NO_EVENT},
        '{8'hAB, 1'b0, 1'b0, NO_EVENT},
        '{8'hCD, 1'b0, 1'b0, NO_EVENT},
        '{8'h01, 1'b0, 1'b0, NO_EVENT},
        '{8'h02, 1'b0, 1'b0, NO_EVENT},
        '{8'h03, 1'b0, 1'b0, NO_EVENT},
        '{8'h04, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, 1'b0, NO_EVENT},
        '{8'h00, 1'b1, 1'b1, '{mpsr_pkg::EV_UNKNOWN, mpsr_pkg::CLASS_AUDIO, 8'h00,
                               16'hABCD, 32'h01020304, 1'b0}},
        // Two packets taken against a count of two, so this byte reports end.
        '{8'h7F, 1'b1, 1'b1, END_EVENT}
    };

    function automatic bit id_listed(input logic [15:0] id, input logic [3:0] n,
                                     input logic [63:0] lo, input logic [63:0] hi);
        logic [127:0] words;
        int           lim;
        words = {hi, lo};
        lim = (n > 4'(mpsr_pkg::MAX_IDS)) ? int'(mpsr_pkg::MAX_IDS) : int'(n);
        for (int k = 0; k < lim; k++) begin
            if (words[16*k +: 16] == id) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void store_register(input logic [2:0] idx, input logic [63:0] value);
        case (idx)
            mpsr_pkg::CFG_PACKET_COUNT:   lim_packets = value[31:0];
            mpsr_pkg::CFG_AUDIO_COUNT:    audio_n     = value[3:0];
            mpsr_pkg::CFG_AUDIO_IDS_LOW:  audio_lo    = value;
            mpsr_pkg::CFG_AUDIO_IDS_HIGH: audio_hi    = value;
            mpsr_pkg::CFG_VIDEO_COUNT:    video_n     = value[3:0];
            mpsr_pkg::CFG_VIDEO_IDS_LOW:  video_lo    = value;
            mpsr_pkg::CFG_VIDEO_IDS_HIGH: video_hi    = value;
            default: ;
        endcase
    endfunction

    // Advances the parse state by one byte and returns 1 when the byte raises an event.
    function automatic bit route_byte(input logic [7:0] b, output mpsr_pkg::result_t ev);
        bit audio_hit;
        bit video_hit;
        ev = '0;
        if (rt_phase == mpsr_pkg::PH_BODY && body_left != 16'd0) begin
            body_left = body_left - 16'd1;
            if (body_left == 16'd0) begin
                rt_phase = mpsr_pkg::PH_HEADER;
                hdr_pos  = 4'd0;
            end
            if (!pkt_forward) return 1'b0;
            ev.event_res        = mpsr_pkg::EV_PAYLOAD;
            ev.stream_class     = pkt_class;
            ev.payload_byte     = b;
            ev.packet_stream_id = pkt_id;
            ev.packet_time      = pkt_time;
            ev.last_of_packet   = (body_left == 16'd0);
            return 1'b1;
        end
        rt_phase = mpsr_pkg::PH_HEADER;
        if (hdr_pos >= mpsr_pkg::HEADER_BYTES) hdr_pos = 4'd0;
        if (hdr_pos == 4'd0 && pkts_taken >= lim_packets) begin
            ev.event_res = mpsr_pkg::EV_END;
            return 1'b1;
        end
        case (hdr_pos)
            mpsr_pkg::HDR_LEN_HI: pkt_len = {b, 8'h00};
            mpsr_pkg::HDR_LEN_LO: begin
                pkt_len[7:0] = b;
                if (pkt_len < mpsr_pkg::HEADER_BYTES) begin
                    body_left   = pkt_len;
                    pkt_forward = 1'b0;
                    hdr_pos     = 4'd0;
                    if (body_left != 16'd0) rt_phase = mpsr_pkg::PH_BODY;
                    ev.event_res = mpsr_pkg::EV_BAD_LENGTH;
                    return 1'b1;
                end
            end
            mpsr_pkg::HDR_ID_HI, mpsr_pkg::HDR_ID_LO: pkt_id = {pkt_id[7:0], b};
            mpsr_pkg::HDR_TIME_0, mpsr_pkg::HDR_TIME_1,
            mpsr_pkg::HDR_TIME_2, mpsr_pkg::HDR_TIME_3: pkt_time = {pkt_time[23:0], b};
            mpsr_pkg::HDR_FLAGS: begin
                audio_hit  = id_listed(pkt_id, audio_n, audio_lo, audio_hi);
                video_hit  = id_listed(pkt_id, video_n, video_lo, video_hi);
                pkts_taken = pkts_taken + 32'd1;
                body_left  = pkt_len - 16'(mpsr_pkg::HEADER_BYTES);
                hdr_pos    = 4'd0;
                pkt_class  = video_hit ? mpsr_pkg::CLASS_VIDEO : mpsr_pkg::CLASS_AUDIO;
                ev.packet_stream_id = pkt_id;
                ev.packet_time      = pkt_time;
                if (!audio_hit && !video_hit) begin
                    pkt_class   = mpsr_pkg::CLASS_AUDIO;
                    pkt_forward = 1'b0;
                    if (body_left != 16'd0) rt_phase = mpsr_pkg::PH_BODY;
                    ev.event_res = mpsr_pkg::EV_UNKNOWN;
                    return 1'b1;
                end
                pkt_forward = 1'b1;
                if (body_left == 16'd0) begin
                    ev.event_res    = mpsr_pkg::EV_EMPTY;
                    ev.stream_class = pkt_class;
                    return 1'b1;
                end
                rt_phase = mpsr_pkg::PH_BODY;
                return 1'b0;
            end
            default: ;
        endcase
        hdr_pos = hdr_pos + 4'd1;
        return 1'b0;
    endfunction

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= 10) $display("%0t ERROR: %s", $time, what);
    endtask

    // Input and output transactions, plus register writes, are all sampled here.
    always @(posedge aclk) begin : monitor
        byte_row_t         offered;
        mpsr_pkg::result_t predicted;
        mpsr_pkg::result_t want;
        bit                produces;
        if (aresetn) begin
            if (cfg_we) store_register(cfg_index, cfg_wdata);
            if (s_valid && s_ready) begin
                offered  = offered_bytes.pop_front();
                produces = route_byte(s_data_byte, predicted);
                if (offered.given) begin
                    produces  = offered.has_event;
                    predicted = offered.want;
                end
                if (produces) routed_events.push_back(predicted);
                bytes_taken++;
            end
            if (m_valid && m_ready) begin
                if (routed_events.size() == 0) begin
                    flag_error($sformatf("event %0d arrived with nothing pending", m_event_res));
                end else begin
                    want = routed_events.pop_front();
                    if (m_event_res !== want.event_res || m_stream_class !== want.stream_class
                        || m_payload_byte !== want.payload_byte
                        || m_packet_stream_id !== want.packet_stream_id
                        || m_packet_time !== want.packet_time
                        || m_last_of_packet !== want.last_of_packet)
                        flag_error($sformatf({"expected ev=%0d cls=%0d byte=%02h id=%04h ",
                            "time=%08h last=%0d, got ev=%0d cls=%0d byte=%02h id=%04h ",
                            "time=%08h last=%0d"},
                            want.event_res, want.stream_class, want.payload_byte,
                            want.packet_stream_id, want.packet_time, want.last_of_packet,
                            m_event_res, m_stream_class, m_payload_byte,
                            m_packet_stream_id, m_packet_time, m_last_of_packet));
                end
                if (m_event_res <= mpsr_pkg::EV_END) event_counts[m_event_res]++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic bit sender_gap();
        if (send_burst != 0) begin
            send_burst--;
            return 1'b0;
        end
        if ($urandom_range(0, 99) < 3) begin
            send_burst = $urandom_range(10, 40);
            return 1'b0;
        end
        return $urandom_range(0, 99) < send_idle_pct;
    endfunction

    function automatic bit receiver_gap();
        if (recv_burst != 0) begin
            recv_burst--;
            return 1'b0;
        end
        if ($urandom_range(0, 99) < 3) begin
            recv_burst = $urandom_range(10, 40);
            return 1'b0;
        end
        return $urandom_range(0, 99) < recv_idle_pct;
    endfunction

    // Receiver: random back-pressure, plus long hold-offs on request.
    initial begin : receiver
        int holds_done;
        holds_done = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= !receiver_gap();
            end
        end
    end

    task automatic send_byte(input byte_row_t row);
        while (sender_gap()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= row.data;
        offered_bytes.push_back(row);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // Stops offering bytes and waits until every predicted event has been delivered.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (routed_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [15:0] listed_id(input logic [3:0] n, input logic [63:0] lo,
                                              input logic [63:0] hi);
        logic [127:0] words;
        int           lim;
        words = {hi, lo};
        lim = (n > 4'(mpsr_pkg::MAX_IDS)) ? int'(mpsr_pkg::MAX_IDS) : int'(n);
        if (lim == 0) return 16'($urandom);
        return words[16*$urandom_range(0, lim - 1) +: 16];
    endfunction

    function automatic int payload_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return $urandom_range(0, 6);
        if (pick < 95) return $urandom_range(7, 30);
        return $urandom_range(31, 120);
    endfunction

    // A bad length carries only the first four header bytes, then that many dropped bytes.
    task automatic push_packet(input logic [15:0] len, input logic [15:0] id);
        logic [31:0] stamp;
        int          body;
        stamp = $urandom;
        phase_bytes.push_back(8'($urandom));
        phase_bytes.push_back(8'($urandom));
        phase_bytes.push_back(len[15:8]);
        phase_bytes.push_back(len[7:0]);
        if (len < mpsr_pkg::HEADER_BYTES) begin
            body = int'(len);
        end else begin
            phase_bytes.push_back(id[15:8]);
            phase_bytes.push_back(id[7:0]);
            for (int k = 3; k >= 0; k--) phase_bytes.push_back(stamp[8*k +: 8]);
            phase_bytes.push_back(8'($urandom));
            phase_bytes.push_back(8'($urandom));
            body = int'(len) - int'(mpsr_pkg::HEADER_BYTES);
        end
        repeat (body) phase_bytes.push_back(8'($urandom));
    endtask

    task automatic run_phase(input int p);
        logic [31:0] limit;
        logic [3:0]  a_n;
        logic [3:0]  v_n;
        logic [63:0] a_lo;
        logic [63:0] a_hi;
        logic [63:0] v_lo;
        logic [63:0] v_hi;
        logic [15:0] id;
        int          target;
        int          pick;
        int          split_at;
        int          half;
        int          sent;
        if (p < 2) begin
            send_idle_pct = 27;
            recv_idle_pct = 70;
        end else if (p < 4) begin
            send_idle_pct = 70;
            recv_idle_pct = 27;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        wait_quiet();
        a_lo   = {$urandom, $urandom};
        a_hi   = {$urandom, $urandom};
        v_lo   = {$urandom, $urandom};
        v_hi   = {$urandom, $urandom};
        limit  = '1;
        a_n    = 4'd8;
        v_n    = 4'd8;
        target = PHASE_TARGET;
        case (p)
            1: begin
                limit  = '0;
                a_n    = 4'd0;
                v_n    = 4'd0;
                target = 0;
            end
            2: begin
                // Counts above the list size, and one id shared by both lists.
                a_n         = 4'd15;
                v_n         = 4'd9;
                a_lo[15:0]  = v_lo[31:16];
            end
            3: begin
                limit = pkts_taken + 32'd4;
                a_n   = 4'd3;
                v_n   = 4'd2;
            end
            4: begin
                a_n = 4'd1;
                v_n = 4'd0;
            end
            5: v_n = 4'd0;
            default: begin
                a_lo[15:0]  = 16'h0000;
                v_hi[63:48] = 16'hFFFF;
            end
        endcase
        write_register(mpsr_pkg::CFG_PACKET_COUNT, {32'h0, limit});
        write_register(mpsr_pkg::CFG_AUDIO_COUNT, {60'h0, a_n});
        write_register(mpsr_pkg::CFG_AUDIO_IDS_LOW, a_lo);
        write_register(mpsr_pkg::CFG_AUDIO_IDS_HIGH, a_hi);
        write_register(mpsr_pkg::CFG_VIDEO_COUNT, {60'h0, v_n});
        write_register(mpsr_pkg::CFG_VIDEO_IDS_LOW, v_lo);
        write_register(mpsr_pkg::CFG_VIDEO_IDS_HIGH, v_hi);
        cfg_we <= 1'b0;
        settings_used++;

        // A header left half done by the previous phase finishes under the new lists.
        while (carry_bytes.size() != 0) phase_bytes.push_back(carry_bytes.pop_front());
        if (p == 1) repeat (12) phase_bytes.push_back(8'($urandom));
        if (p == 2) push_packet(16'd11, 16'h0000);
        while (phase_bytes.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) id = listed_id(a_n, a_lo, a_hi);
            else if (pick < 80) id = listed_id(v_n, v_lo, v_hi);
            else id = 16'($urandom);
            if ($urandom_range(0, 99) < 8) push_packet(16'($urandom_range(0, 11)), id);
            else push_packet(16'(mpsr_pkg::HEADER_BYTES + payload_size()), id);
        end
        if (p == 4) begin
            split_at = phase_bytes.size() + 7;
            push_packet(16'(mpsr_pkg::HEADER_BYTES + 3), listed_id(a_n, a_lo, a_hi));
            while (phase_bytes.size() > split_at) carry_bytes.push_front(phase_bytes.pop_back());
        end
        if (p == 6) begin
            // Only the opening bytes of a maximum-length packet go out; the run ends inside it.
            split_at = phase_bytes.size() + 30;
            push_packet(16'hFFFF, listed_id(v_n, v_lo, v_hi));
            while (phase_bytes.size() > split_at) void'(phase_bytes.pop_back());
        end

        half = phase_bytes.size() / 2;
        sent = 0;
        while (phase_bytes.size() != 0) begin
            if ((p == 0 || p == 2 || p == 4) && sent == half)
                hold_requests <= hold_requests + 1;
            send_byte('{phase_bytes.pop_front(), 1'b0, 1'b0, NO_EVENT});
            sent++;
        end
    endtask

    initial begin : stimulus
        int drained;
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        send_idle_pct = 27;
        recv_idle_pct = 70;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        settings_used = 1;

        for (int r = 0; r < DIRECTED_COUNT; r++) begin
            if (r == CONFIG_ROW) begin
                wait_quiet();
                write_register(mpsr_pkg::CFG_PACKET_COUNT, 64'd2);
                write_register(mpsr_pkg::CFG_AUDIO_COUNT, 64'd1);
                write_register(mpsr_pkg::CFG_AUDIO_IDS_LOW, 64'h1234);
                write_register(mpsr_pkg::CFG_VIDEO_COUNT, 64'd1);
                write_register(mpsr_pkg::CFG_VIDEO_IDS_LOW, 64'h1234);
                cfg_we <= 1'b0;
                settings_used++;
            end
            send_byte(directed_rows[r]);
        end

        for (int p = 0; p < PHASES; p++) run_phase(p);

        s_valid <= 1'b0;
        drained = 0;
        while (routed_events.size() != 0 && drained < DRAIN_LIMIT) begin
            @(posedge aclk);
            drained++;
        end
        repeat (10) @(posedge aclk);
        if (routed_events.size() != 0)
            flag_error($sformatf("%0d predicted events never arrived", routed_events.size()));

        $display("Sent %0d bytes through %0d register settings, with random stalls on both sides.",
                 bytes_taken, settings_used);
        $display("Events seen: payload %0d, empty %0d, bad length %0d, unknown %0d, end %0d.",
                 event_counts[0], event_counts[1], event_counts[2], event_counts[3],
                 event_counts[4]);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- media_packet_stream_router.f -----
design/mpsr_pkg.sv
design/media_packet_stream_router.sv
test/tb_top.sv
